[src/stepper_speed_to_period_assert.svh]
// ---------------------------------------------------------------------------
// Stepper speed to period assertion macros
// Concurrent assertion helpers clocked on clk_i and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef STEPPER_SPEED_TO_PERIOD_ASSERT_SVH
`define STEPPER_SPEED_TO_PERIOD_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SSP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/ssp_pkg.sv]
// ---------------------------------------------------------------------------
// Stepper speed to period package
// Field widths, operation and register codes, item and divider types.
// ---------------------------------------------------------------------------
`default_nettype none

package ssp_pkg;

  localparam int PERIOD_BITS_DEF     = 16;
  localparam int STEP_COUNT_BITS_DEF = 32;

  localparam int OP_W       = 3;
  localparam int SPEED_W    = 16;
  localparam int LIMIT_W    = 15;
  localparam int NUM_W      = 24;
  localparam int PERIOD_W   = 16;
  localparam int STEPS_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [NUM_W-1:0]   NUM_RESET       = 24'd1125;
  localparam logic [LIMIT_W-1:0] MIN_SPEED_RESET = 15'd10;
  localparam logic [LIMIT_W-1:0] MAX_SPEED_RESET = 15'd4000;
  localparam logic [LIMIT_W-1:0] OFF_DELAY_RESET = 15'd1000;

  localparam logic [OP_W-1:0] OP_SPEED  = 3'd0;
  localparam logic [OP_W-1:0] OP_TICK   = 3'd1;
  localparam logic [OP_W-1:0] OP_STEP_L = 3'd2;
  localparam logic [OP_W-1:0] OP_STEP_R = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_NUM = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_DELAY  = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]           operation;
    logic signed [SPEED_W-1:0] speed_left;
    logic signed [SPEED_W-1:0] speed_right;
  } in_item_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] period_left;
    logic [PERIOD_W-1:0] period_right;
    logic                run_left;
    logic                run_right;
    logic                dir_left_pin;
    logic                dir_right_pin;
    logic                driver_enable;
    logic [STEPS_W-1:0]  steps_left;
    logic [STEPS_W-1:0]  steps_right;
    logic [STEPS_W-1:0]  steps_total;
  } out_item_t;

  typedef struct packed {
    logic               start;
    logic [NUM_W-1:0]   dividend;
    logic [LIMIT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

[src/ssp_divider.sv]
// ---------------------------------------------------------------------------
// Stepper speed to period divider
// Restoring divider producing one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module ssp_divider (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ssp_pkg::div_req_t req_i,
  output ssp_pkg::div_rsp_t      rsp_o
);

  localparam int NW    = ssp_pkg::NUM_W;
  localparam int DW    = ssp_pkg::LIMIT_W;
  localparam int CNT_W = $clog2(NW);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DW-1:0]    rem_q;
  logic [NW-1:0]    quo_q;
  logic [DW-1:0]    den_q;

  logic [DW:0]   trial;
  logic [DW+1:0] diff;
  logic          ge;
  logic          last;

  assign trial = {rem_q, quo_q[NW-1]};
  assign diff  = {1'b0, trial} - {2'b00, den_q};
  assign ge    = !diff[DW+1];
  assign last  = (cnt_q == CNT_W'(NW - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      den_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
      quo_q <= {quo_q[NW-2:0], ge};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

`default_nettype wire

[src/stepper_speed_to_period.sv]
// A speed command runs each moving wheel in turn through the shared 24-step divider;
// a stopped wheel does not use the divider.
// Ticks, step events and clears go straight to the done state. A result is loaded into
// the free output register; the block is ready for a new item in the cycle after that.
// Reset is asynchronous and active low; it restores the register defaults and clears
// all countdown, run, direction, period and step count state.
// ---------------------------------------------------------------------------
// Stepper speed to period controller
// Turns wheel speed commands into step periods, direction pins and run flags,
// manages driver power with an idle countdown and counts step events until cleared.
// ---------------------------------------------------------------------------
`default_nettype none

`include "stepper_speed_to_period_assert.svh"

module stepper_speed_to_period #(
  parameter int PERIOD_BITS     = ssp_pkg::PERIOD_BITS_DEF,
  parameter int STEP_COUNT_BITS = ssp_pkg::STEP_COUNT_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire ssp_pkg::in_item_t                in_item_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output ssp_pkg::out_item_t                    out_item_o,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [ssp_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [ssp_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int PB  = PERIOD_BITS;
  localparam int SCB = STEP_COUNT_BITS;
  localparam int NW  = ssp_pkg::NUM_W;
  localparam int LW  = ssp_pkg::LIMIT_W;
  localparam int SW  = ssp_pkg::SPEED_W;
  localparam int PW  = ssp_pkg::PERIOD_W;
  localparam int CW  = ssp_pkg::STEPS_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOAD = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  localparam logic [PB-1:0] PERIOD_MAX = {PB{1'b1}};

  logic [1:0]     state_q;
  logic           wheel_q;
  logic [NW-1:0]  num_q;
  logic [LW-1:0]  min_q;
  logic [LW-1:0]  max_q;
  logic [LW-1:0]  off_q;
  logic [15:0]    countdown_q;
  logic           cd_done_q;
  logic           enable_q;
  logic [1:0]     run_q;
  logic [1:0]     dir_q;
  logic [PB-1:0]  period_q [2];
  logic [SCB-1:0] steps_q [3];
  logic [SW-1:0]  spd_l_q;
  logic [SW-1:0]  spd_r_q;
  logic           out_valid_q;
  ssp_pkg::out_item_t out_item_q;

  logic               accept;
  logic               out_load;
  logic [SW-1:0]      spd_sel;
  logic               neg;
  logic [SW-1:0]      mag_raw;
  logic [SW-1:0]      mag_min;
  logic [SW-1:0]      mag_clamp;
  logic [NW+PB-1:0]   quo_ext;
  logic [PB-1:0]      quo_sat;
  logic [PB+PW-1:0]   per_l_ext;
  logic [PB+PW-1:0]   per_r_ext;
  logic [SCB+CW-1:0]  stl_ext;
  logic [SCB+CW-1:0]  str_ext;
  logic [SCB+CW-1:0]  stt_ext;
  ssp_pkg::div_req_t  div_req;
  ssp_pkg::div_rsp_t  div_rsp;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_load    = (state_q == S_DONE) && (!out_valid_q || out_ready_i);
  assign cfg_ready_o = 1'b1;

  assign spd_sel   = wheel_q ? spd_r_q : spd_l_q;
  assign neg       = spd_sel[SW-1];
  assign mag_raw   = neg ? (SW'(0) - spd_sel) : spd_sel;
  assign mag_min   = (mag_raw < {1'b0, min_q}) ? {1'b0, min_q} : mag_raw;
  assign mag_clamp = (mag_min > {1'b0, max_q}) ? {1'b0, max_q} : mag_min;

  assign div_req.start    = (state_q == S_LOAD) && (spd_sel != '0) && (mag_clamp != '0);
  assign div_req.dividend = num_q;
  assign div_req.divisor  = mag_clamp[LW-1:0];

  ssp_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign quo_ext = {PB'(0), div_rsp.quotient};
  assign quo_sat = (quo_ext > {NW'(0), PERIOD_MAX}) ? PERIOD_MAX : quo_ext[PB-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q <= ssp_pkg::NUM_RESET;
      min_q <= ssp_pkg::MIN_SPEED_RESET;
      max_q <= ssp_pkg::MAX_SPEED_RESET;
      off_q <= ssp_pkg::OFF_DELAY_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ssp_pkg::REG_PERIOD_NUM: num_q <= cfg_data_i[NW-1:0];
        ssp_pkg::REG_MIN_SPEED:  min_q <= cfg_data_i[LW-1:0];
        ssp_pkg::REG_MAX_SPEED:  max_q <= cfg_data_i[LW-1:0];
        ssp_pkg::REG_OFF_DELAY:  off_q <= cfg_data_i[LW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wheel_q     <= 1'b0;
      countdown_q <= '0;
      cd_done_q   <= 1'b0;
      enable_q    <= 1'b0;
      run_q       <= '0;
      dir_q       <= '0;
      period_q[0] <= '0;
      period_q[1] <= '0;
      steps_q[0]  <= '0;
      steps_q[1]  <= '0;
      steps_q[2]  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_DONE;
            case (in_item_i.operation)
              ssp_pkg::OP_SPEED: begin
                countdown_q <= {1'b0, off_q};
                cd_done_q   <= 1'b0;
                enable_q    <= 1'b1;
                wheel_q     <= 1'b0;
                state_q     <= S_LOAD;
              end
              ssp_pkg::OP_TICK: begin
                if (!cd_done_q) begin
                  if (countdown_q != '0) begin
                    countdown_q <= countdown_q - 16'd1;
                  end else begin
                    enable_q    <= 1'b0;
                    run_q       <= '0;
                    period_q[0] <= '0;
                    period_q[1] <= '0;
                    cd_done_q   <= 1'b1;
                  end
                end
              end
              ssp_pkg::OP_STEP_L: begin
                steps_q[0] <= steps_q[0] + SCB'(1);
                steps_q[2] <= steps_q[2] + SCB'(1);
              end
              ssp_pkg::OP_STEP_R: begin
                steps_q[1] <= steps_q[1] + SCB'(1);
                steps_q[2] <= steps_q[2] + SCB'(1);
              end
              ssp_pkg::OP_CLEAR: begin
                steps_q[0] <= '0;
                steps_q[1] <= '0;
                steps_q[2] <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        S_LOAD: begin
          if (spd_sel == '0) begin
            period_q[wheel_q] <= '0;
            run_q[wheel_q]    <= 1'b0;
            wheel_q           <= 1'b1;
            state_q           <= wheel_q ? S_DONE : S_LOAD;
          end else begin
            dir_q[wheel_q] <= neg ^ wheel_q;
            run_q[wheel_q] <= 1'b1;
            if (mag_clamp == '0) begin
              period_q[wheel_q] <= PERIOD_MAX;
              wheel_q           <= 1'b1;
              state_q           <= wheel_q ? S_DONE : S_LOAD;
            end else begin
              state_q <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            period_q[wheel_q] <= quo_sat;
            wheel_q           <= 1'b1;
            state_q           <= wheel_q ? S_DONE : S_LOAD;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      spd_l_q <= in_item_i.speed_left;
      spd_r_q <= in_item_i.speed_right;
    end
  end

  assign per_l_ext = {PW'(0), period_q[0]};
  assign per_r_ext = {PW'(0), period_q[1]};
  assign stl_ext   = {CW'(0), steps_q[0]};
  assign str_ext   = {CW'(0), steps_q[1]};
  assign stt_ext   = {CW'(0), steps_q[2]};

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_item_q.period_left   <= per_l_ext[PW-1:0];
      out_item_q.period_right  <= per_r_ext[PW-1:0];
      out_item_q.run_left      <= run_q[0];
      out_item_q.run_right     <= run_q[1];
      out_item_q.dir_left_pin  <= dir_q[0];
      out_item_q.dir_right_pin <= dir_q[1];
      out_item_q.driver_enable <= enable_q;
      out_item_q.steps_left    <= stl_ext[CW-1:0];
      out_item_q.steps_right   <= str_ext[CW-1:0];
      out_item_q.steps_total   <= stt_ext[CW-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `SSP_ASSERT_NEXT(a_busy_after_accept, accept, !in_ready_o,
                   "Block still ready in the cycle after taking an item.")
  `SSP_ASSERT_NOW(a_off_means_stopped, !enable_q, run_q == 2'b00,
                  "A wheel runs while the driver is off.")
  `SSP_ASSERT_NOW(a_div_done_in_wait, div_rsp.done, state_q == S_DIV,
                  "Divider finished outside the wait state.")
  `SSP_ASSERT_NOW(a_stopped_zero_period, !run_q[0], period_q[0] == '0,
                  "Stopped left wheel holds a nonzero period.")

endmodule

`default_nettype wire
